// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the line rasterizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define LR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is held.
`define LR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/lr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lr_pkg;

    localparam int COORD_BITS   = 16;
    localparam int COLOR_BITS   = 24;
    localparam int DIM_BITS     = 15;
    localparam int SPAN_BITS    = COORD_BITS;
    localparam int DIFF_BITS    = COORD_BITS + 1;
    localparam int ERR_BITS     = COORD_BITS + 2;
    localparam int CMP_BITS     = ((COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS) + 1;
    localparam int STATUS_BITS  = 3;
    localparam int CFG_IDX_BITS = 1;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic        [COLOR_BITS-1:0] t_color;
    typedef logic        [DIM_BITS-1:0]   t_dim;
    typedef logic        [SPAN_BITS-1:0]  t_span;
    typedef logic signed [ERR_BITS-1:0]   t_err;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_HEIGHT = 1'b1;

    localparam t_dim SCREEN_WIDTH_RESET  = t_dim'(1024);
    localparam t_dim SCREEN_HEIGHT_RESET = t_dim'(768);

    typedef enum logic [1:0] {
        KIND_VERT = 2'd0,
        KIND_HOR  = 2'd1,
        KIND_DIAG = 2'd2,
        KIND_GEN  = 2'd3
    } t_kind;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_ACCEPT = 3'd0,
        ST_REJECT = 3'd1,
        ST_EMPTY  = 3'd2,
        ST_PIXEL  = 3'd3,
        ST_IDLE   = 3'd4
    } t_status;

    // One input item after endpoint decoding.
    typedef struct packed {
        logic   opcode;
        logic   reject;
        logic   empty;
        t_coord start_x;
        t_coord start_y;
        t_coord end_x;
        t_coord end_y;
        t_color color;
        logic   col_neg;
        logic   row_neg;
        t_span  span_col;
        t_span  span_row;
        t_kind  kind;
        t_err   err_init;
    } t_load;

    // Handoff between the decode register and the stepping core.
    typedef struct packed {
        logic  valid;
        t_load load;
    } t_stage;

endpackage

`default_nettype wire

// ===== hdl/lr_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface lr_in_if import lr_pkg::*; ();
    logic   valid;
    logic   ready;
    logic   opcode;
    t_coord start_x;
    t_coord start_y;
    t_coord end_x;
    t_coord end_y;
    t_color line_color;

    modport source (output valid, opcode, start_x, start_y, end_x, end_y, line_color,
                    input ready);
    modport sink (input valid, opcode, start_x, start_y, end_x, end_y, line_color,
                  output ready);
endinterface

interface lr_out_if import lr_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [STATUS_BITS-1:0] status;
    t_coord                 pixel_x;
    t_coord                 pixel_y;
    t_color                 pixel_color;
    logic                   last_pixel;

    modport source (output valid, status, pixel_x, pixel_y, pixel_color, last_pixel,
                    input ready);
    modport sink (input valid, status, pixel_x, pixel_y, pixel_color, last_pixel,
                  output ready);
endinterface

`default_nettype wire

// ===== hdl/lr_prep.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

// Input register: decodes the endpoints of a load (rejection, spans,
// directions, line class) so that the core only applies them.
module lr_prep import lr_pkg::*; (
    input  wire       i_clk,
    input  wire       i_rst_n,
    lr_in_if.sink     i_in,
    input  t_dim      i_screen_width,
    input  t_dim      i_screen_height,
    input  wire       i_take,
    output t_stage    o_stage
);

    logic  r_valid;
    t_load r_load;
    t_load n_load;
    logic  in_xfer;

    logic signed [CMP_BITS-1:0]  ax_c, ay_c, bx_c, by_c, w_c, h_c;
    logic signed [DIFF_BITS-1:0] dpos_x, dneg_x, dpos_y, dneg_y;

    assign i_in.ready = !r_valid || i_take;
    assign in_xfer    = i_in.valid && i_in.ready;

    always_comb begin
        ax_c = CMP_BITS'(i_in.start_x);
        ay_c = CMP_BITS'(i_in.start_y);
        bx_c = CMP_BITS'(i_in.end_x);
        by_c = CMP_BITS'(i_in.end_y);
        w_c  = $signed({{(CMP_BITS-DIM_BITS){1'b0}}, i_screen_width});
        h_c  = $signed({{(CMP_BITS-DIM_BITS){1'b0}}, i_screen_height});

        dpos_x = DIFF_BITS'(i_in.end_x) - DIFF_BITS'(i_in.start_x);
        dneg_x = DIFF_BITS'(i_in.start_x) - DIFF_BITS'(i_in.end_x);
        dpos_y = DIFF_BITS'(i_in.end_y) - DIFF_BITS'(i_in.start_y);
        dneg_y = DIFF_BITS'(i_in.start_y) - DIFF_BITS'(i_in.end_y);

        n_load.opcode  = i_in.opcode;
        n_load.reject  = (ax_c >= w_c && bx_c >= w_c)
                      || (i_in.start_x < 0 && i_in.end_x < 0)
                      || (ay_c >= h_c && by_c >= h_c)
                      || (i_in.start_y < 0 && i_in.end_y < 0);
        n_load.empty   = (i_in.start_x == i_in.end_x) && (i_in.start_y == i_in.end_y);
        n_load.start_x = i_in.start_x;
        n_load.start_y = i_in.start_y;
        n_load.end_x   = i_in.end_x;
        n_load.end_y   = i_in.end_y;
        n_load.color   = i_in.line_color;
        n_load.col_neg = i_in.end_x < i_in.start_x;
        n_load.row_neg = i_in.end_y < i_in.start_y;
        n_load.span_col = n_load.col_neg ? dneg_x[SPAN_BITS-1:0] : dpos_x[SPAN_BITS-1:0];
        n_load.span_row = n_load.row_neg ? dneg_y[SPAN_BITS-1:0] : dpos_y[SPAN_BITS-1:0];

        if (i_in.start_x == i_in.end_x) begin
            n_load.kind = KIND_VERT;
        end else if (i_in.start_y == i_in.end_y) begin
            n_load.kind = KIND_HOR;
        end else if (n_load.span_col == n_load.span_row) begin
            n_load.kind = KIND_DIAG;
        end else begin
            n_load.kind = KIND_GEN;
        end

        n_load.err_init = $signed({2'b00, n_load.span_col}) - $signed({2'b00, n_load.span_row});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (in_xfer) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
        if (in_xfer) begin
            r_load <= n_load;
        end
    end

    assign o_stage.valid = r_valid;
    assign o_stage.load  = r_load;

    // A decoded item that the core has not taken must stay put.
    `LR_ASSERT_NEXT(a_hold_stage, i_clk, i_rst_n, r_valid && !i_take, r_valid && $stable(r_load))

endmodule

`default_nettype wire

// ===== hdl/lr_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

// Line state and result register. A good load replaces the line state; a rejected or empty load ends the
// active line; a step advances the position by one pixel and reports a pixel of the line.
module lr_core import lr_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  t_stage     i_stage,
    output logic       o_take,
    lr_out_if.source   o_out
);

    // Line state.
    t_coord r_cur_col, r_cur_row, r_goal_col, r_goal_row;
    logic   r_col_neg, r_row_neg;
    t_span  r_span_col, r_span_row;
    t_err   r_err;
    t_kind  r_kind;
    logic   r_active;
    t_color r_pen_color;

    // Result register.
    logic    r_out_valid;
    t_status r_status;
    t_coord  r_px, r_py;
    t_color  r_color;
    logic    r_last;

    t_coord  col_step, row_step;
    t_coord  n_cur_col, n_cur_row;
    t_err    n_err;
    logic    n_active;
    t_status n_status;
    t_coord  n_px, n_py;
    t_color  n_color;
    logic    n_last;
    logic    go_col;
    logic signed [ERR_BITS:0] e2, neg_span_row;

    t_load ld;
    assign ld = i_stage.load;

    assign o_take = i_stage.valid && (!r_out_valid || o_out.ready);

    always_comb begin
        col_step = r_col_neg ? r_cur_col - t_coord'(1) : r_cur_col + t_coord'(1);
        row_step = r_row_neg ? r_cur_row - t_coord'(1) : r_cur_row + t_coord'(1);
        e2           = {r_err, 1'b0};
        neg_span_row = -$signed({3'b000, r_span_row});
        go_col       = e2 >= neg_span_row;

        n_cur_col = r_cur_col;
        n_cur_row = r_cur_row;
        n_err     = r_err;
        n_active  = r_active;
        n_status  = ST_IDLE;
        n_px      = '0;
        n_py      = '0;
        n_color   = '0;
        n_last    = 1'b0;

        if (ld.opcode == OP_LOAD) begin
            n_active = 1'b0;
            if (ld.reject) begin
                n_status = ST_REJECT;
            end else if (ld.empty) begin
                n_status = ST_EMPTY;
            end else begin
                n_status = ST_ACCEPT;
                n_active = 1'b1;
            end
        end else if (r_active) begin
            n_status = ST_PIXEL;
            n_color  = r_pen_color;
            if (r_kind == KIND_GEN) begin
                // One axis per pixel; the start pixel is skipped.
                if (go_col) begin
                    n_err     = r_err - $signed({2'b00, r_span_row});
                    n_cur_col = col_step;
                end else begin
                    n_err     = r_err + $signed({2'b00, r_span_col});
                    n_cur_row = row_step;
                end
                n_px   = n_cur_col;
                n_py   = n_cur_row;
                n_last = (n_cur_col == r_goal_col) && (n_cur_row == r_goal_row);
            end else begin
                n_px = r_cur_col;
                n_py = r_cur_row;
                if (r_kind != KIND_VERT) begin
                    n_cur_col = col_step;
                end
                if (r_kind != KIND_HOR) begin
                    n_cur_row = row_step;
                end
                n_last = (r_kind == KIND_VERT) ? (n_cur_row == r_goal_row)
                                               : (n_cur_col == r_goal_col);
            end
            if (n_last) begin
                n_active = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_active    <= n_active;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end

        if (o_take) begin
            r_status <= n_status;
            r_px     <= n_px;
            r_py     <= n_py;
            r_color  <= n_color;
            r_last   <= n_last;
            if (ld.opcode == OP_LOAD && !ld.reject && !ld.empty) begin
                r_cur_col   <= ld.start_x;
                r_cur_row   <= ld.start_y;
                r_goal_col  <= ld.end_x;
                r_goal_row  <= ld.end_y;
                r_col_neg   <= ld.col_neg;
                r_row_neg   <= ld.row_neg;
                r_span_col  <= ld.span_col;
                r_span_row  <= ld.span_row;
                r_err       <= ld.err_init;
                r_kind      <= ld.kind;
                r_pen_color <= ld.color;
            end else if (ld.opcode == OP_STEP && r_active) begin
                r_cur_col <= n_cur_col;
                r_cur_row <= n_cur_row;
                r_err     <= n_err;
            end
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_status;
    assign o_out.pixel_x     = r_px;
    assign o_out.pixel_y     = r_py;
    assign o_out.pixel_color = r_color;
    assign o_out.last_pixel  = r_last;

    // A step with no active line reports idle.
    `LR_ASSERT_NEXT(a_idle_step, i_clk, i_rst_n, o_take && ld.opcode == OP_STEP && !r_active, r_status == ST_IDLE)
    // A good load always starts a line.
    `LR_ASSERT_NEXT(a_load_active, i_clk, i_rst_n, o_take && ld.opcode == OP_LOAD && !ld.reject && !ld.empty, r_active)
    // The final pixel leaves the block idle.
    `LR_ASSERT_IMPL(a_last_idle, i_clk, i_rst_n, r_out_valid && r_last, !r_active && r_status == ST_PIXEL)

endmodule

`default_nettype wire

// ===== hdl/line_rasterizer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Line rasterizer with one result per input transfer. A load transfer
// (opcode 0) checks the two signed endpoints against the screen size for
// trivial rejection, flags an empty line, and otherwise classes the line as
// vertical, horizontal, diagonal or general and makes it active. Each step
// transfer (opcode 1) returns the next pixel of the active line with its color
// and a last-pixel mark, or status idle when no line is active. Straight and
// diagonal lines produce the start pixel through the pixel before the end; a
// general line moves one axis per pixel (a 4-connected path), skips the start
// pixel and ends on the end pixel. Pixels are not clipped individually.
// Throughput is one transfer per clock in both directions while the receiver
// takes each result. An input transfer passes through the input decode
// register, which resolves rejection, spans, directions and the line class,
// and from there through the line state update into the result register. When a
// result waits on a stalled receiver, the decode register still takes one
// more transfer; after that the input ready stays low until the result
// leaves. The input ready depends combinationally on the output ready.
// The screen width and height registers (indexes 0 and 1, reset 1024 and 768)
// may only be written while no transfer is in flight.
module line_rasterizer import lr_pkg::*; (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_cfg_we,
    input  wire [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire [DIM_BITS-1:0]      i_cfg_data,
    lr_in_if.sink                   i_in,
    lr_out_if.source                o_out
);

    // Configuration registers used only by rejection.
    t_dim r_screen_width;
    t_dim r_screen_height;

    t_stage stage;
    logic   take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_width  <= SCREEN_WIDTH_RESET;
            r_screen_height <= SCREEN_HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_SCREEN_WIDTH:  r_screen_width  <= i_cfg_data;
                REG_SCREEN_HEIGHT: r_screen_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Decode stage: endpoint checks and line setup values.
    lr_prep u_prep (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in            (i_in),
        .i_screen_width  (r_screen_width),
        .i_screen_height (r_screen_height),
        .i_take          (take),
        .o_stage         (stage)
    );

    // Line state, pixel stepping and the result register.
    lr_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stage (stage),
        .o_take  (take),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire
